// ===== rtl/crwq_pkg.sv =====
// Types and constants for the core reservation wait queue.
// No dependencies; used by the top level, the checker and the queue RAM users.
`default_nettype none

package crwq_pkg;

    // Cores that can ever be handed out; a larger configured total acts as this.
    localparam logic [6:0] CORE_LIMIT = 7'd64;

    // Transaction kinds
    localparam logic KIND_RESERVE = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] requester;
        logic [6:0] core_count;
    } t_req;

    typedef struct packed {
        logic       granted;
        logic [5:0] first_core;
        logic       queued;
        logic       queue_overflow;
        logic       release_underflow;
        logic       woken_valid;
        logic [7:0] woken_requester;
        logic [6:0] woken_cores;
        logic [6:0] active_after;
    } t_result;

    // One pending queue entry
    typedef struct packed {
        logic [7:0] requester;
        logic [6:0] need;
    } t_entry;

    // A need fits when active + need stays within the clamped total.
    function automatic logic fits(input logic [6:0] active, input logic [6:0] need,
                                  input logic [6:0] total);
        logic [6:0] eff;
        eff = (total > CORE_LIMIT) ? CORE_LIMIT : total;
        return ({1'b0, active} + {1'b0, need}) <= {1'b0, eff};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/crwq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module crwq_ram #(
    parameter int WIDTH  = 15,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/core_reservation_wait_queue.sv =====
// Reserve: result strobe in the cycle after start and busy stays low, so reserves run every
// cycle while no release is in progress. Release: with an empty queue the result comes
// in the cycle after start, else the queue is scanned and a woken entry is removed; busy
// drops as the strobe rises. The queue RAM read port visits one entry per cycle, first
// scanning for a fit and then moving later entries down one slot.
// Results cannot be stalled. Synchronous active-low reset clears the count, the fill
// and the sequencer and sets the total to 64; queue contents are not cleared.
// Uses crwq_pkg and crwq_ram.
`default_nettype none

module core_reservation_wait_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire crwq_pkg::t_req   i_item,
    input  wire logic             i_cfg_we,
    input  wire logic [6:0]       i_cfg_wdata,
    output logic                  o_result_valid,
    output crwq_pkg::t_result     o_result
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int EW = $bits(crwq_pkg::t_entry);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_SHIFT = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [6:0]        r_total, n_total;
    logic [6:0]        r_active, n_active;
    logic [CW-1:0]     r_fill, n_fill;
    logic [CW-1:0]     r_pend, n_pend;
    logic              r_underflow, n_underflow;
    crwq_pkg::t_entry  r_woken, n_woken;
    crwq_pkg::t_result r_result, n_result;
    logic              r_result_valid, n_result_valid;

    logic              accept;
    logic [CW:0]       pend_inc;
    logic [CW-1:0]     pend_dec;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    crwq_pkg::t_entry  ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [EW-1:0]     ram_rdata;
    crwq_pkg::t_entry  rd_entry;

    assign busy     = (r_state != ST_IDLE);
    assign accept   = start && !busy;
    assign pend_inc = {1'b0, r_pend} + (CW+1)'(1);
    assign pend_dec = r_pend - CW'(1);
    assign rd_entry = crwq_pkg::t_entry'(ram_rdata);

    // Queue storage: requester id and need per entry
    crwq_ram #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (EW'(ram_wdata)),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Sequencer and next-state logic
    always_comb begin
        n_state        = r_state;
        n_total        = i_cfg_we ? i_cfg_wdata : r_total;
        n_active       = r_active;
        n_fill         = r_fill;
        n_pend         = r_pend;
        n_underflow    = r_underflow;
        n_woken        = r_woken;
        n_result       = r_result;
        n_result_valid = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = pend_dec[AW-1:0];
        ram_wdata      = rd_entry;
        // read one past the entry now on the read data; entry 0 when starting
        ram_raddr      = (r_state == ST_IDLE) ? AW'(0) : pend_inc[AW-1:0];

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_result = '0;
                    if (i_item.kind == crwq_pkg::KIND_RESERVE) begin
                        n_result_valid = 1'b1;
                        if (crwq_pkg::fits(r_active, i_item.core_count, r_total)) begin
                            n_result.granted    = 1'b1;
                            n_result.first_core = r_active[5:0];
                            n_active            = r_active + i_item.core_count;
                        end else if (r_fill < CW'(QUEUE_DEPTH)) begin
                            // 8-bit ids are always below the requester limit of 256
                            ram_we                   = 1'b1;
                            ram_waddr                = r_fill[AW-1:0];
                            ram_wdata.requester      = i_item.requester;
                            ram_wdata.need           = i_item.core_count;
                            n_fill                   = r_fill + CW'(1);
                            n_result.queued          = 1'b1;
                        end else begin
                            n_result.queue_overflow  = 1'b1;
                        end
                        n_result.active_after = n_active;
                    end else begin
                        // release: clamp at zero
                        if (i_item.core_count > r_active) begin
                            n_active    = '0;
                            n_underflow = 1'b1;
                        end else begin
                            n_active    = r_active - i_item.core_count;
                            n_underflow = 1'b0;
                        end
                        if (r_fill == '0) begin
                            n_result_valid             = 1'b1;
                            n_result.release_underflow = n_underflow;
                            n_result.active_after      = n_active;
                        end else begin
                            n_pend  = '0;
                            n_state = ST_SCAN;
                        end
                    end
                end
            end

            ST_SCAN: begin
                // rd_entry holds entry r_pend
                if (crwq_pkg::fits(r_active, rd_entry.need, r_total)) begin
                    n_woken = rd_entry;
                    n_pend  = pend_inc[CW-1:0];
                    n_state = ST_SHIFT;
                end else if (pend_inc >= {1'b0, r_fill}) begin
                    n_result_valid             = 1'b1;
                    n_result                   = '0;
                    n_result.release_underflow = r_underflow;
                    n_result.active_after      = r_active;
                    n_state                    = ST_IDLE;
                end else begin
                    n_pend = pend_inc[CW-1:0];
                end
            end

            ST_SHIFT: begin
                // move entry r_pend down one slot, keeping order
                if (r_pend < r_fill) begin
                    ram_we = 1'b1;
                    n_pend = pend_inc[CW-1:0];
                end else begin
                    n_fill                     = r_fill - CW'(1);
                    n_result_valid             = 1'b1;
                    n_result                   = '0;
                    n_result.release_underflow = r_underflow;
                    n_result.woken_valid       = 1'b1;
                    n_result.woken_requester   = r_woken.requester;
                    n_result.woken_cores       = r_woken.need;
                    n_result.active_after      = r_active;
                    n_state                    = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_total        <= 7'd64;
            r_active       <= '0;
            r_fill         <= '0;
            r_pend         <= '0;
            r_underflow    <= 1'b0;
            r_result_valid <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_total        <= n_total;
            r_active       <= n_active;
            r_fill         <= n_fill;
            r_pend         <= n_pend;
            r_underflow    <= n_underflow;
            r_result_valid <= n_result_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_woken  <= n_woken;
        r_result <= n_result;
    end

    assign o_result_valid = r_result_valid;
    assign o_result       = r_result;

endmodule

`default_nettype wire

// ===== rtl/crwq_checker.sv =====
// Port-level checks for core_reservation_wait_queue, attached by bind.
// Uses crwq_pkg.
`default_nettype none

module crwq_checker (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire crwq_pkg::t_req    i_item,
    input wire logic              o_result_valid,
    input wire crwq_pkg::t_result o_result
);

    // A reserve transaction answers in the next cycle
    a_reserve_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.kind == crwq_pkg::KIND_RESERVE) |=> o_result_valid)
        else $error("reserve result missing");

    // At most one reserve outcome per result
    a_one_outcome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |->
            $onehot0({o_result.granted, o_result.queued, o_result.queue_overflow}))
        else $error("conflicting reserve outcomes");

    // Reserve and release fields never mix
    a_no_mix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_result.granted || o_result.queued ||
                            o_result.queue_overflow))
            |-> !(o_result.woken_valid || o_result.release_underflow))
        else $error("reserve result carries release fields");

    // The active count never exceeds the core limit
    a_active_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_result.active_after <= crwq_pkg::CORE_LIMIT))
        else $error("active count above core limit");

    // An accepted release keeps the block busy or answers at once
    a_release_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.kind == crwq_pkg::KIND_RELEASE)
            |=> (busy || o_result_valid))
        else $error("release transaction lost");

endmodule

bind core_reservation_wait_queue crwq_checker u_crwq_checker (.*);

`default_nettype wire
